// ===== rtl/sgr_pkg.sv =====
`default_nettype none
package sgr_pkg;

    localparam int MAX_HEIGHT_DEF = 16;
    localparam int CHAR_COUNT_DEF = 256;

    localparam int OP_W   = 2;
    localparam int CODE_W = 8;
    localparam int ROW_W  = 4;
    localparam int BITS_W = 32;
    localparam int CWID_W = 6;
    localparam int POS_W  = 16;
    localparam int HGT_W  = 5;
    localparam int MASK_W = 33;

    localparam logic [HGT_W-1:0] HEIGHT_RESET = 5'd8;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD_ROW  = 2'd0,
        OP_SET_WIDTH = 2'd1,
        OP_DRAW      = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WIDTH,
        ST_ROWS,
        ST_ULINE
    } seq_state_t;

    typedef struct packed {
        logic [CODE_W-1:0]       code;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic                    bold;
        logic                    italic;
        logic                    underline;
    } draw_cmd_t;

endpackage
`default_nettype wire

// ===== rtl/sgr_if.sv =====
`default_nettype none
interface sgr_item_if;
    import sgr_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          operation;
    logic [CODE_W-1:0]        char_code;
    logic [ROW_W-1:0]         row_index;
    logic [BITS_W-1:0]        row_bits;
    logic [CWID_W-1:0]        char_width;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic                     bold;
    logic                     italic;
    logic                     underline;

    modport source (
        output valid, operation, char_code, row_index, row_bits, char_width,
               pos_x, pos_y, bold, italic, underline,
        input  ready
    );

    modport sink (
        input  valid, operation, char_code, row_index, row_bits, char_width,
               pos_x, pos_y, bold, italic, underline,
        output ready
    );
endinterface

interface sgr_span_if;
    import sgr_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [POS_W-1:0]  span_x;
    logic signed [POS_W-1:0]  span_y;
    logic [MASK_W-1:0]        span_mask;
    logic                     last;

    modport source (
        output valid, span_x, span_y, span_mask, last,
        input  ready
    );

    modport sink (
        input  valid, span_x, span_y, span_mask, last,
        output ready
    );
endinterface
`default_nettype wire

// ===== rtl/sgr_glyph_ram.sv =====
`default_nettype none
module sgr_glyph_ram #(
    parameter int DEPTH = 4096,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                      clk,
    input  logic                      we,
    input  logic [AW-1:0]             waddr,
    input  logic [sgr_pkg::BITS_W-1:0] wdata,
    input  logic                      re,
    input  logic [AW-1:0]             raddr,
    output logic [sgr_pkg::BITS_W-1:0] rdata
);
    import sgr_pkg::*;

    logic [BITS_W-1:0] mem [DEPTH];
    logic [BITS_W-1:0] rdata_reg;

    // read data holds until the next read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ===== rtl/sgr_width_ram.sv =====
`default_nettype none
module sgr_width_ram #(
    parameter int CHAR_COUNT = 256,
    localparam int IW = $clog2(CHAR_COUNT)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       we,
    input  logic [IW-1:0]              waddr,
    input  logic [sgr_pkg::CWID_W-1:0] wdata,
    input  logic                       re,
    input  logic [IW-1:0]              raddr,
    output logic [sgr_pkg::CWID_W-1:0] rdata
);
    import sgr_pkg::*;

    logic [CWID_W-1:0]     mem [CHAR_COUNT];
    logic [CWID_W-1:0]     rdata_reg;
    logic [CHAR_COUNT-1:0] valid_reg;
    logic                  rvalid_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    // entries never written read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            if (re)
            begin
                rvalid_reg <= valid_reg[raddr];
            end
        end
    end

    assign rdata = rvalid_reg ? rdata_reg : '0;

endmodule
`default_nettype wire

// ===== rtl/sgr_draw_seq.sv =====
`default_nettype none
module sgr_draw_seq #(
    parameter int MAX_HEIGHT = 16,
    parameter int CHAR_COUNT = 256,
    localparam int HW = $clog2(MAX_HEIGHT + 1),
    localparam int DEPTH = CHAR_COUNT * MAX_HEIGHT,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  sgr_pkg::draw_cmd_t          cmd,
    input  logic [HW-1:0]               height,
    input  logic [sgr_pkg::CWID_W-1:0]  width_rdata,
    output logic                        glyph_re,
    output logic [AW-1:0]               glyph_raddr,
    input  logic [sgr_pkg::BITS_W-1:0]  glyph_rdata,
    output logic                        idle,
    sgr_span_if.source                  span
);
    import sgr_pkg::*;

    seq_state_t        state_reg, state_next;
    draw_cmd_t         cmd_reg;
    logic [HW-1:0]     h_reg;
    logic [AW-1:0]     base_reg;
    logic [MASK_W-1:0] lenmask_reg;
    logic [HW-1:0]     issue_v_reg, issue_v_next;
    logic [HW-1:0]     out_v_reg, out_v_next;
    logic              pend_reg, pend_next;
    logic              out_valid_reg, out_valid_next;
    logic [POS_W-1:0]  sx_reg, sx_next;
    logic [POS_W-1:0]  sy_reg, sy_next;
    logic [MASK_W-1:0] mask_reg, mask_next;
    logic              last_reg, last_next;

    logic [CWID_W:0]   n;
    logic [MASK_W-1:0] lenmask_calc;
    logic              out_free;
    logic              take;
    logic              row_done;
    logic [HW-1:0]     slope;
    logic [MASK_W-1:0] row_ext;
    logic [MASK_W-1:0] row_mask;

    // span length is width plus bold, capped at the full mask
    assign n = {1'b0, width_rdata} + {{CWID_W{1'b0}}, cmd_reg.bold};
    assign lenmask_calc = (n >= 7'd33) ? {MASK_W{1'b1}}
                                       : MASK_W'((64'd1 << n) - 64'd1);

    assign out_free = !out_valid_reg || span.ready;
    assign take     = (state_reg == ST_ROWS) && pend_reg && out_free;
    assign row_done = (out_v_reg == h_reg - HW'(1));

    assign slope    = cmd_reg.italic ? ((h_reg - out_v_reg) >> 2) : '0;
    assign row_ext  = {1'b0, glyph_rdata};
    assign row_mask = (cmd_reg.bold ? (row_ext | (row_ext << 1)) : row_ext) & lenmask_reg;

    assign glyph_raddr = base_reg + AW'(issue_v_reg);
    assign idle        = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        issue_v_next   = issue_v_reg;
        out_v_next     = out_v_reg;
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg && !span.ready;
        sx_next        = sx_reg;
        sy_next        = sy_reg;
        mask_next      = mask_reg;
        last_next      = last_reg;
        glyph_re       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    issue_v_next = '0;
                    out_v_next   = '0;
                    pend_next    = 1'b0;
                    state_next   = ST_WIDTH;
                end
            end
            ST_WIDTH:
            begin
                if (h_reg != '0)
                begin
                    glyph_re     = 1'b1;
                    issue_v_next = HW'(1);
                    pend_next    = 1'b1;
                    state_next   = ST_ROWS;
                end
                else if (cmd_reg.underline)
                begin
                    state_next = ST_ULINE;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_ROWS:
            begin
                if (take)
                begin
                    out_valid_next = 1'b1;
                    sx_next        = $unsigned(cmd_reg.pos_x) + POS_W'(slope);
                    sy_next        = $unsigned(cmd_reg.pos_y) + POS_W'(out_v_reg);
                    mask_next      = row_mask;
                    last_next      = !cmd_reg.underline && row_done;
                    out_v_next     = out_v_reg + HW'(1);
                    pend_next      = 1'b0;
                    if (row_done)
                    begin
                        state_next = cmd_reg.underline ? ST_ULINE : ST_IDLE;
                    end
                end
                // next row read goes out as soon as the held row is consumed
                if ((issue_v_reg != h_reg) && (!pend_reg || take))
                begin
                    glyph_re     = 1'b1;
                    issue_v_next = issue_v_reg + HW'(1);
                    pend_next    = 1'b1;
                end
            end
            ST_ULINE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    sx_next        = $unsigned(cmd_reg.pos_x);
                    sy_next        = $unsigned(cmd_reg.pos_y) + POS_W'(h_reg) + POS_W'(1);
                    mask_next      = lenmask_reg;
                    last_next      = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            issue_v_reg   <= '0;
            out_v_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            issue_v_reg   <= issue_v_next;
            out_v_reg     <= out_v_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_IDLE) && start)
        begin
            cmd_reg  <= cmd;
            h_reg    <= height;
            base_reg <= AW'({24'b0, cmd.code} * 32'(MAX_HEIGHT));
        end
        if (state_reg == ST_WIDTH)
        begin
            lenmask_reg <= lenmask_calc;
        end
        sx_reg   <= sx_next;
        sy_reg   <= sy_next;
        mask_reg <= mask_next;
        last_reg <= last_next;
    end

    assign span.valid     = out_valid_reg;
    assign span.span_x    = sx_reg;
    assign span.span_y    = sy_reg;
    assign span.span_mask = mask_reg;
    assign span.last      = last_reg;

endmodule
`default_nettype wire

// ===== rtl/styled_glyph_row_renderer_unit.sv =====
`default_nettype none
// Bitmap font character generator. Load-row and set-width words write the glyph RAM
// (one 32-bit word per glyph row) or the width table. A draw word first looks up the
// width table, then reads h glyph rows, one row per cycle when the span side does not
// stall, through the single read port of the glyph RAM, and then sends an underline
// span if underline is set. item.ready is low while a draw is in progress; the last span
// may still sit in the output register when the next word is taken. h is glyph_height
// capped at MAX_HEIGHT. Glyph rows must be loaded before they are drawn; the width table
// reads as zero until written. glyph_height is written through cfg_wr_en/cfg_wr_data;
// the user must write it only while the unit is idle, which the unit does not enforce.
module styled_glyph_row_renderer_unit #(
    parameter int MAX_HEIGHT = sgr_pkg::MAX_HEIGHT_DEF,
    parameter int CHAR_COUNT = sgr_pkg::CHAR_COUNT_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [sgr_pkg::HGT_W-1:0] cfg_wr_data,
    sgr_item_if.sink                  item,
    sgr_span_if.source                span
);
    import sgr_pkg::*;

    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int DEPTH = CHAR_COUNT * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IW    = $clog2(CHAR_COUNT);

    logic [HGT_W-1:0]  glyph_height_reg;
    logic              accept;
    logic              code_ok;
    logic              row_ok;
    logic              glyph_we;
    logic [AW-1:0]     glyph_waddr;
    logic              glyph_re;
    logic [AW-1:0]     glyph_raddr;
    logic [BITS_W-1:0] glyph_rdata;
    logic              width_we;
    logic              draw_start;
    logic [CWID_W-1:0] width_rdata;
    logic [HW-1:0]     height_eff;
    logic              seq_idle;
    draw_cmd_t         cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            glyph_height_reg <= HEIGHT_RESET;
        end
        else if (cfg_wr_en)
        begin
            glyph_height_reg <= cfg_wr_data;
        end
    end

    assign item.ready = seq_idle;
    assign accept     = item.valid && item.ready;

    // codes past the table and rows past the glyph are dropped
    assign code_ok = {1'b0, item.char_code} < (CODE_W + 1)'(CHAR_COUNT);
    assign row_ok  = {28'b0, item.row_index} < 32'(MAX_HEIGHT);

    assign glyph_we    = accept && code_ok && row_ok && (item.operation == OP_LOAD_ROW);
    assign glyph_waddr = AW'({24'b0, item.char_code} * 32'(MAX_HEIGHT)
                             + {28'b0, item.row_index});
    assign width_we    = accept && code_ok && (item.operation == OP_SET_WIDTH);
    assign draw_start  = accept && code_ok && (item.operation == OP_DRAW);

    assign height_eff = ({27'b0, glyph_height_reg} > 32'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT)
                                                                      : HW'(glyph_height_reg);

    assign cmd.code      = item.char_code;
    assign cmd.pos_x     = item.pos_x;
    assign cmd.pos_y     = item.pos_y;
    assign cmd.bold      = item.bold;
    assign cmd.italic    = item.italic;
    assign cmd.underline = item.underline;

    sgr_glyph_ram #(
        .DEPTH (DEPTH)
    ) u_glyph_ram (
        .clk   (clk),
        .we    (glyph_we),
        .waddr (glyph_waddr),
        .wdata (item.row_bits),
        .re    (glyph_re),
        .raddr (glyph_raddr),
        .rdata (glyph_rdata)
    );

    sgr_width_ram #(
        .CHAR_COUNT (CHAR_COUNT)
    ) u_width_ram (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (width_we),
        .waddr (item.char_code[IW-1:0]),
        .wdata (item.char_width),
        .re    (draw_start),
        .raddr (item.char_code[IW-1:0]),
        .rdata (width_rdata)
    );

    sgr_draw_seq #(
        .MAX_HEIGHT (MAX_HEIGHT),
        .CHAR_COUNT (CHAR_COUNT)
    ) u_draw_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (draw_start),
        .cmd         (cmd),
        .height      (height_eff),
        .width_rdata (width_rdata),
        .glyph_re    (glyph_re),
        .glyph_raddr (glyph_raddr),
        .glyph_rdata (glyph_rdata),
        .idle        (seq_idle),
        .span        (span)
    );

endmodule
`default_nettype wire
